// File: sv/dgc_pkg.sv
package dgc_pkg;

  // Palette storage
  localparam int PALETTE_DEPTH = 4;
  localparam int NUM_COLOR_REGS = 4;
  localparam int COLOR_IDX_W = 2;
  localparam int COUNT_W = 3;

  // Field widths
  localparam int DEPTH_W = 11;
  localparam int POS_W = 16;
  localparam int COLOR_W = 24;
  localparam int CHAN_W = 8;
  localparam int NUM_CHAN = 3;

  // Gradient position carries 23 fraction bits (Q4.12 scaled by 2^11)
  localparam int FRAC_W = 23;
  localparam int SPAN_W = POS_W + 1;
  localparam int PROD_W = SPAN_W + DEPTH_W + 1;
  localparam int GPOS_W = PROD_W;
  localparam int SCALED_W = FRAC_W + COLOR_IDX_W;
  localparam int BLEND_W = CHAN_W + 1 + FRAC_W + 1;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_NEAR_POSITION = 3'd0,
    REG_FAR_POSITION  = 3'd1,
    REG_PALETTE_COUNT = 3'd2,
    REG_COLOR_0       = 3'd3,
    REG_COLOR_1       = 3'd4,
    REG_COLOR_2       = 3'd5,
    REG_COLOR_3       = 3'd6
  } cfg_reg_t;

  localparam logic signed [POS_W-1:0] NEAR_RESET = 16'sd6840;
  localparam logic signed [POS_W-1:0] FAR_RESET = -16'sd7291;

  typedef logic [COLOR_W-1:0] color_t;

endpackage

// File: sv/depth_gradient_colormap.sv
// Channel | Direction | Handshake              | Payload
// --------+-----------+------------------------+-------------------------------------
// in      | input     | in_valid / in_stall    | depth_sample[10:0], frame_end_in
// out     | output    | out_valid / out_stall  | red, green, blue [7:0], frame_end_out
// cfg     | input     | cfg_valid / cfg_ready  | cfg_index[2:0], cfg_data[23:0]
//
// Five register stages.
// One transaction per cycle while out_stall is low: each stage reloads whenever it is empty
// or the stage after it moves, so bubbles close up under backpressure.
// Stage depth is set by the widest product: 9 x 24 bit channel blend.
// Reset (rst, synchronous) empties the pipeline and loads register defaults.
// cfg_ready always high; user must write registers only while pipe idle; unchecked.
module depth_gradient_colormap (
  input  logic                              clk,
  input  logic                              rst,
  // sample channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [dgc_pkg::DEPTH_W-1:0]       depth_sample,
  input  logic                              frame_end_in,
  // pixel channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [dgc_pkg::CHAN_W-1:0]        red,
  output logic [dgc_pkg::CHAN_W-1:0]        green,
  output logic [dgc_pkg::CHAN_W-1:0]        blue,
  output logic                              frame_end_out,
  // register write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dgc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [dgc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import dgc_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [POS_W-1:0] near_position;
  logic signed [POS_W-1:0] far_position;
  logic [COUNT_W-1:0]      palette_count;
  color_t                  color0, color1, color2, color3;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_position <= NEAR_RESET;
      far_position  <= FAR_RESET;
      palette_count <= '0;
      color0        <= '0;
      color1        <= '0;
      color2        <= '0;
      color3        <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NEAR_POSITION: near_position <= cfg_data[POS_W-1:0];
        REG_FAR_POSITION:  far_position  <= cfg_data[POS_W-1:0];
        REG_PALETTE_COUNT: palette_count <= cfg_data[COUNT_W-1:0];
        REG_COLOR_0:       color0        <= cfg_data[COLOR_W-1:0];
        REG_COLOR_1:       color1        <= cfg_data[COLOR_W-1:0];
        REG_COLOR_2:       color2        <= cfg_data[COLOR_W-1:0];
        REG_COLOR_3:       color3        <= cfg_data[COLOR_W-1:0];
        default: ;  // unknown index: dropped
      endcase
    end
  end

  // Derived from config only, static while samples flow
  logic signed [SPAN_W-1:0] span;
  logic [COUNT_W-1:0]       n_used;
  logic [COLOR_IDX_W-1:0]   last_idx;

  assign span = SPAN_W'(far_position) - SPAN_W'(near_position);

  always_comb begin
    if (palette_count > COUNT_W'(PALETTE_DEPTH)) begin
      n_used = COUNT_W'(PALETTE_DEPTH);
    end else begin
      n_used = palette_count;
    end
    last_idx = COLOR_IDX_W'(n_used - COUNT_W'(1));
  end

  function automatic color_t pick(input logic [COLOR_IDX_W-1:0] idx,
                                  input color_t c0, input color_t c1,
                                  input color_t c2, input color_t c3);
    color_t r;
    case (idx)
      2'd0:    r = c0;
      2'd1:    r = c1;
      2'd2:    r = c2;
      default: r = c3;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Pipeline flow control: a stage loads when empty or when its successor moves
  // ---------------------------------------------------------------------------
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5     = !out_valid || !out_stall;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) out_valid <= v4;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: span * depth
  // ---------------------------------------------------------------------------
  logic signed [PROD_W-1:0] p1_prod;
  logic                     p1_fe;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      p1_prod <= span * $signed({1'b0, depth_sample});
      p1_fe   <= frame_end_in;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: gradient position = near * 2^11 + span * depth (units of 2^-23)
  // ---------------------------------------------------------------------------
  logic signed [GPOS_W-1:0] p2_pos;
  logic                     p2_fe;
  logic signed [GPOS_W-1:0] near_scaled;

  assign near_scaled = {GPOS_W'(near_position)} <<< DEPTH_W;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      p2_pos <= near_scaled + p1_prod;
      p2_fe  <= p1_fe;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: segment select and fraction
  // ---------------------------------------------------------------------------
  logic                   pos_neg, pos_ge_one;
  logic [SCALED_W-1:0]    scaled;
  logic [COLOR_IDX_W-1:0] seg;
  color_t                 lo_next, hi_next;
  logic [FRAC_W-1:0]      frac_next;

  color_t            p3_lo, p3_hi;
  logic [FRAC_W-1:0] p3_frac;
  logic              p3_fe;

  always_comb begin
    pos_neg    = p2_pos[GPOS_W-1];
    pos_ge_one = !pos_neg && (p2_pos[GPOS_W-2:FRAC_W] != '0);
    // pos < 1 here, so scaled < (n-1)*2^23 and the segment never passes n-2
    scaled     = SCALED_W'(p2_pos[FRAC_W-1:0]) * SCALED_W'(last_idx);
    seg        = scaled[SCALED_W-1:FRAC_W];
    frac_next  = '0;
    if (n_used == '0) begin
      lo_next = '0;
      hi_next = '0;
    end else if (n_used == COUNT_W'(1) || pos_neg) begin
      lo_next = color0;
      hi_next = color0;
    end else if (pos_ge_one) begin
      lo_next = pick(last_idx, color0, color1, color2, color3);
      hi_next = lo_next;
    end else begin
      lo_next   = pick(seg, color0, color1, color2, color3);
      hi_next   = pick(seg + COLOR_IDX_W'(1), color0, color1, color2, color3);
      frac_next = scaled[FRAC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      p3_lo   <= lo_next;
      p3_hi   <= hi_next;
      p3_frac <= frac_next;
      p3_fe   <= p2_fe;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: per-channel (hi - lo) * frac, keep the integer step
  // ---------------------------------------------------------------------------
  logic [CHAN_W-1:0] p4_base [NUM_CHAN];
  logic [CHAN_W-1:0] p4_step [NUM_CHAN];
  logic              p4_fe;

  logic signed [CHAN_W:0]    diff [NUM_CHAN];
  logic signed [BLEND_W-1:0] blend [NUM_CHAN];

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      diff[c]  = $signed({1'b0, p3_hi[CHAN_W*(NUM_CHAN-1-c) +: CHAN_W]})
               - $signed({1'b0, p3_lo[CHAN_W*(NUM_CHAN-1-c) +: CHAN_W]});
      blend[c] = diff[c] * $signed({1'b0, p3_frac});
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        p4_base[c] <= p3_lo[CHAN_W*(NUM_CHAN-1-c) +: CHAN_W];
        // floor division by 2^23; base + step stays in 0..255 so mod 256 is exact
        p4_step[c] <= blend[c][FRAC_W +: CHAN_W];
      end
      p4_fe <= p3_fe;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rdy5) begin
      red           <= p4_base[0] + p4_step[0];
      green         <= p4_base[1] + p4_step[1];
      blue          <= p4_base[2] + p4_step[2];
      frame_end_out <= p4_fe;
    end
  end

endmodule
